/* rtl/core/mcg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and calendar helpers for the month calendar grid.
package mcg_pkg;

  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int DayW   = 5;
  localparam int WdayW  = 3;

  localparam logic [YearW-1:0]  BaseYear     = 14'd1900;
  localparam logic [6:0]        BaseMod100   = 7'd0;
  localparam logic [8:0]        BaseMod400   = 9'd300;
  localparam logic [1:0]        BaseMod4     = 2'd0;
  // 1 Jan 1900 fell on a Monday
  localparam logic [WdayW-1:0]  BaseWeekday  = 3'd1;
  localparam logic [WdayW-1:0]  Saturday     = 3'd6;
  localparam logic [MonthW-1:0] January      = 4'd1;
  localparam logic [MonthW-1:0] February     = 4'd2;
  localparam logic [MonthW-1:0] December     = 4'd12;

  typedef struct packed {
    logic in_ready;
    logic year_step;
    logic month_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic req_ok;
    logic years_done;
    logic months_done;
    logic out_free;
    logic last_day;
  } sts_t;

  // days in a month of a common year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m) inside
      February:                 len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // month length modulo 7, common year
  function automatic logic [WdayW-1:0] month_shift(input logic [MonthW-1:0] m);
    logic [WdayW-1:0] sh;
    case (m) inside
      February:                 sh = 3'd0;
      4'd4, 4'd6, 4'd9, 4'd11:  sh = 3'd2;
      default:                  sh = 3'd3;
    endcase
    return sh;
  endfunction

  // (a + b) mod 7 for a, b both below 7
  function automatic logic [WdayW-1:0] add_mod7(input logic [WdayW-1:0] a,
                                                input logic [WdayW-1:0] b);
    logic [WdayW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) s = s - 4'd7;
    return s[WdayW-1:0];
  endfunction

endpackage

/* rtl/core/mcg_req_if.sv */
`timescale 1ns / 1ps
// Request channel: month and year of the wanted calendar.
interface mcg_req_if;
  logic                        valid;
  logic                        ready;
  logic [mcg_pkg::MonthW-1:0]  month;
  logic [mcg_pkg::YearW-1:0]   year;

  modport source (output valid, month, year, input ready);
  modport sink   (input valid, month, year, output ready);
endinterface

/* rtl/core/mcg_day_if.sv */
`timescale 1ns / 1ps
// Day channel: one grid cell of the month per transfer.
interface mcg_day_if;
  logic                        valid;
  logic                        ready;
  logic [mcg_pkg::DayW-1:0]    day_number;
  logic [mcg_pkg::WdayW-1:0]   weekday;
  logic                        row_end;
  logic                        last;

  modport source (output valid, day_number, weekday, row_end, last, input ready);
  modport sink   (input valid, day_number, weekday, row_end, last, output ready);
endinterface

/* rtl/core/mcg_datapath.sv */
`timescale 1ns / 1ps
// Datapath: year/month weekday accumulation, day counter and output register.
module mcg_datapath (
  input  logic            clk,
  input  logic            rst,
  mcg_req_if.sink         req,
  mcg_day_if.source       grid,
  input  mcg_pkg::cmd_t   cmd,
  output mcg_pkg::sts_t   sts
);

  logic [mcg_pkg::MonthW-1:0] month_tgt;
  logic [mcg_pkg::YearW-1:0]  year_tgt;
  logic [mcg_pkg::YearW-1:0]  year_cnt;
  logic [1:0]                 mod4;
  logic [6:0]                 mod100;
  logic [8:0]                 mod400;
  logic [mcg_pkg::WdayW-1:0]  wd;
  logic [mcg_pkg::MonthW-1:0] month_idx;
  logic [mcg_pkg::DayW-1:0]   day;
  logic [mcg_pkg::DayW-1:0]   total;
  logic                       leap;
  logic                       out_valid;
  logic [mcg_pkg::DayW-1:0]   out_day;
  logic [mcg_pkg::WdayW-1:0]  out_wd;
  logic                       out_row_end;
  logic                       out_last;
  logic                       load;

  // leap test of the year the counter stands on
  assign leap  = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign total = mcg_pkg::month_len(month_tgt)
               + {4'd0, (month_tgt == mcg_pkg::February) && leap};

  assign load      = req.valid && cmd.in_ready;
  assign req.ready = cmd.in_ready;

  assign sts.accept      = load;
  assign sts.req_ok      = (req.month >= mcg_pkg::January) && (req.month <= mcg_pkg::December)
                         && (req.year >= mcg_pkg::BaseYear);
  assign sts.years_done  = (year_cnt == year_tgt);
  assign sts.months_done = (month_idx == month_tgt);
  assign sts.out_free    = !out_valid || grid.ready;
  assign sts.last_day    = (day == total);

  always_ff @(posedge clk) begin
    if (load) begin
      month_tgt <= req.month;
      year_tgt  <= req.year;
      year_cnt  <= mcg_pkg::BaseYear;
      mod4      <= mcg_pkg::BaseMod4;
      mod100    <= mcg_pkg::BaseMod100;
      mod400    <= mcg_pkg::BaseMod400;
      wd        <= mcg_pkg::BaseWeekday;
      month_idx <= mcg_pkg::January;
      day       <= 5'd1;
    end else if (cmd.year_step) begin
      year_cnt <= year_cnt + 14'd1;
      mod4     <= mod4 + 2'd1;
      mod100   <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400   <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      wd       <= mcg_pkg::add_mod7(wd, leap ? 3'd2 : 3'd1);
    end else if (cmd.month_step) begin
      month_idx <= month_idx + 4'd1;
      wd        <= mcg_pkg::add_mod7(wd, mcg_pkg::month_shift(month_idx)
                   + {2'd0, (month_idx == mcg_pkg::February) && leap});
    end else if (cmd.emit) begin
      day <= day + 5'd1;
      wd  <= (wd == mcg_pkg::Saturday) ? 3'd0 : wd + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (grid.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_day     <= day;
      out_wd      <= wd;
      out_row_end <= (wd == mcg_pkg::Saturday);
      out_last    <= sts.last_day;
    end
  end

  assign grid.valid      = out_valid;
  assign grid.day_number = out_day;
  assign grid.weekday    = out_wd;
  assign grid.row_end    = out_row_end;
  assign grid.last       = out_last;

  a_emit_wd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (wd <= mcg_pkg::Saturday))
    else $error("weekday out of range at emit");

  a_year_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.year_step |-> (year_cnt < year_tgt))
    else $error("year counter ran past target");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || grid.ready))
    else $error("emit would overwrite a pending transfer");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_valid && (out_day == $past(day))))
    else $error("emitted day not presented");

endmodule

/* rtl/core/mcg_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences year walk, month walk and day emission.
module mcg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  mcg_pkg::sts_t  sts,
  output mcg_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_YEARS, S_MONTHS, S_EMIT} state_t;

  state_t state;

  always_comb begin
    cmd.in_ready   = (state == S_IDLE);
    cmd.year_step  = (state == S_YEARS) && !sts.years_done;
    cmd.month_step = (state == S_MONTHS) && !sts.months_done;
    cmd.emit       = (state == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          // a bad month or early year is taken and dropped
          if (sts.accept && sts.req_ok) state <= S_YEARS;
        end
        S_YEARS: begin
          if (sts.years_done) state <= S_MONTHS;
        end
        S_MONTHS: begin
          if (sts.months_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free && sts.last_day) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.in_ready, cmd.year_step, cmd.month_step, cmd.emit}))
    else $error("more than one datapath command");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last_day) |=> (state == S_IDLE))
    else $error("no return to idle after final day");

  a_bad_req_dropped: assert property (@(posedge clk) disable iff (rst)
    (sts.accept && !sts.req_ok) |=> (state == S_IDLE))
    else $error("invalid request started work");

endmodule

/* rtl/core/month_calendar_grid.sv */
`timescale 1ns / 1ps
// Top level of the month calendar grid: controller plus datapath.
//
// Usage:
//   req  (sink)  : one transfer carries month (1..12) and year (>= 1900).
//   grid (source): the month's days in order, one transfer per day, with
//                  day_number, weekday (0 = Sunday), row_end on Saturdays
//                  and last on the final day.
// A request with month 0 or 13..15, or a year below 1900, is taken and
// yields no transfers.
// The weekday of the 1st is found by walking years from 1900, one year per
// cycle, then by stepping through each earlier month. Days then leave at
// one per cycle while the receiver keeps ready high. The year port holds
// values up to 16383; one request is worked at a time, and req.ready is
// high only while the block is idle.
// The last day sits in the output register; a new request may be taken
// while it still waits to be read.
// Reset clears the controller to idle and drops any pending output.
// A receiver stall holds the output register and pauses emission.
module month_calendar_grid (
  input  logic      clk,
  input  logic      rst,
  mcg_req_if.sink   req,
  mcg_day_if.source grid
);

  mcg_pkg::cmd_t cmd;
  mcg_pkg::sts_t sts;

  // sequencing only; no data passes through the controller
  mcg_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // weekday accumulation, day counter and output register
  mcg_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .grid (grid),
    .cmd  (cmd),
    .sts  (sts)
  );

endmodule
